// ===== hw/rtl/aod_pkg.sv =====
// Shared types, constants and the alpha lookup table of the onset detector.
// No dependencies; every other file of the block depends on this package.
package aod_pkg;

    localparam int ENERGY_BITS         = 24;
    localparam int ALPHA_TABLE_ENTRIES = 64;
    localparam int ALPHA_X_SPAN        = 8;
    localparam int IDX_W               = $clog2(ALPHA_TABLE_ENTRIES);
    localparam int LEVEL_W             = 24;
    localparam int ENV_W               = (ENERGY_BITS > LEVEL_W) ? ENERGY_BITS : LEVEL_W;
    localparam int DIV_W               = (ENERGY_BITS + 1 > 18) ? ENERGY_BITS + 1 : 18;
    localparam int QUO_W               = 24;
    localparam int DIV_LO_W            = 24;
    localparam int MUL_A_W             = 32;
    localparam int MUL_B_W             = 23;
    localparam int PROD_W              = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 24;

    localparam longint unsigned KCOMP_L = ((64'd1 << ENERGY_BITS) + 64'd10) / 64'd20;
    localparam longint unsigned EPS_L   = ((64'd1 << ENERGY_BITS) + 64'd500000) / 64'd1000000;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [17:0] THREE_Q16 = 18'd196608;
    localparam logic [16:0] K165_Q16  = 17'd108134;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSITIVITY   = 3'd0,
        CFG_ENERGY_FLOOR  = 3'd1,
        CFG_REFRACTORY_US = 3'd2,
        CFG_FAST_RATE     = 3'd3,
        CFG_SLOW_RATE     = 3'd4,
        CFG_LEVEL_RATE    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_FAST,
        SEL_SLOW,
        SEL_LEVEL
    } env_sel_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_REFR,
        OP_AMUL,
        OP_AIDX,
        OP_AIMUL,
        OP_AINT,
        OP_EMUL,
        OP_EUPD,
        OP_CDIV,
        OP_SHAPE,
        OP_FMUL,
        OP_FACT,
        OP_TMUL,
        OP_TEST,
        OP_SAT,
        OP_ODIV,
        OP_OVER,
        OP_SDIV,
        OP_STR,
        OP_WRITE
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REFR,
        ST_AMUL,
        ST_AIDX,
        ST_AIMUL,
        ST_AINT,
        ST_EMUL,
        ST_EUPD,
        ST_CDIV,
        ST_CWAIT,
        ST_SHAPE,
        ST_FMUL,
        ST_FACT,
        ST_TMUL,
        ST_TEST,
        ST_DECIDE,
        ST_SAT,
        ST_ODIV,
        ST_OWAIT,
        ST_OVER,
        ST_OBRANCH,
        ST_SDIV,
        ST_SWAIT,
        ST_STR,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t   op;
        env_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic fire;
        logic str_sat;
        logic over_gt;
        logic div_busy;
    } dp_sts_t;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    rem_init;
        logic [DIV_LO_W-1:0] low;
        logic [DIV_W-1:0]    divisor;
        logic [4:0]          count;
    } div_cmd_t;

    typedef logic [15:0] alpha_tab_t [ALPHA_TABLE_ENTRIES];

    // 1 - exp(-k*span/entries) in Q0.16, exp(-h) from a Taylor series in Q32
    function automatic alpha_tab_t alpha_table_build();
        logic [63:0] one;
        logic [63:0] h;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        logic [63:0] a;
        alpha_tab_t  t;
        one  = 64'd1 << 32;
        h    = (64'(ALPHA_X_SPAN) << 32) / 64'(ALPHA_TABLE_ENTRIES);
        pos  = one;
        neg  = 64'd0;
        term = one;
        for (int n = 1; n <= 24; n++)
        begin
            term = ((term * h) >> 32) / 64'(n);
            if ((n % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        r = pos - neg;
        e = one;
        for (int k = 0; k < ALPHA_TABLE_ENTRIES; k++)
        begin
            a    = (one - e + 64'd32768) >> 16;
            t[k] = (a > 64'd65535) ? 16'hFFFF : a[15:0];
            e    = (e * r + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam alpha_tab_t ALPHA_TAB = alpha_table_build();

endpackage

// ===== hw/rtl/aod_if.sv =====
// Channel interfaces of the onset detector: frame input, result output and
// configuration writes. Depends on aod_pkg for field widths.
interface aod_frame_if;
    logic                            valid;
    logic                            ready;
    logic [aod_pkg::ENERGY_BITS-1:0] energy;
    logic [19:0]                     dt_us;
    modport source (output valid, output energy, output dt_us, input ready);
    modport sink   (input valid, input energy, input dt_us, output ready);
endinterface

interface aod_result_if;
    logic        valid;
    logic        ready;
    logic        onset;
    logic [15:0] strength;
    logic [15:0] level_out;
    modport source (output valid, output onset, output strength, output level_out,
                    input ready);
    modport sink   (input valid, input onset, input strength, input level_out,
                    output ready);
endinterface

interface aod_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aod_pkg::CFG_IDX_W-1:0]  index;
    logic [aod_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/audio_onset_detector.sv =====
// Top level of the envelope-ratio audio onset detector.
// Depends on aod_pkg, aod_if, aod_ctrl, aod_dp (and aod_div below it).
//
//  channel   dir   handshake        payload
//  -------   ---   -------------    -----------------------------------
//  frame     in    valid / ready    energy[23:0], dt_us[19:0]
//  result    out   valid / ready    onset, strength[15:0], level_out[15:0]
//  cfg       in    valid / ready    index[2:0], data[23:0] (always ready)
//
// One frame request is worked at a time. A frame with zero elapsed time
// goes from the load straight to the result write; otherwise the work is
// set by the one-bit-per-cycle divider (24 steps; when an onset fires, up
// to 18 and 17 more) and by the shared multiplier that the three envelope
// updates take in turn.
// Reset clears all envelopes and the countdown and loads default settings.
// The result sits in an output register; a stalled result holds the
// sequencer only at its final step, and a new frame waits until then.
module audio_onset_detector
(
    input  logic    clk,
    input  logic    rst_n,
    aod_frame_if.sink    frame,
    aod_result_if.source result,
    aod_cfg_if.sink      cfg
);
    import aod_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequence the item: load, countdown, three alpha/EMA passes, dividers
    aod_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .frame  (frame),
        .result (result)
    );

    // hold settings and state, run the arithmetic
    aod_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .frame  (frame),
        .result (result),
        .cfg    (cfg)
    );

endmodule

// ===== hw/rtl/aod_div.sv =====
// Restoring divider, one quotient bit per cycle, for the shaping and
// strength quotients. Depends on aod_pkg.
module aod_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  aod_pkg::div_cmd_t cmd,
    output logic              busy,
    output logic [aod_pkg::QUO_W-1:0] quotient
);
    import aod_pkg::*;

    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_LO_W-1:0] lo_reg, lo_next;
    logic [DIV_W-1:0]    dvs_reg, dvs_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;

    assign trial = {rem_reg, lo_reg[DIV_LO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next = rem_reg;
        lo_next  = lo_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.start)
        begin
            rem_next = cmd.rem_init;
            lo_next  = cmd.low;
            dvs_next = cmd.divisor;
            quo_next = '0;
            cnt_next = cmd.count;
        end
        else if (cnt_reg != 5'd0)
        begin
            // trial subtract; remainder stays below the divisor
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            lo_next  = {lo_reg[DIV_LO_W-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 5'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy     = (cnt_reg != 5'd0);
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/aod_dp.sv =====
// Datapath of the onset detector: configuration registers, state, a shared
// multiplier, alpha interpolation and the divider. Depends on aod_pkg, aod_if.
module aod_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  aod_pkg::dp_cmd_t  cmd,
    output aod_pkg::dp_sts_t  sts,
    aod_frame_if.sink         frame,
    aod_result_if.source      result,
    aod_cfg_if.sink           cfg
);
    import aod_pkg::*;

    // configuration
    logic [16:0]            sens_reg;
    logic [ENERGY_BITS-1:0] floor_reg;
    logic [19:0]            refus_reg;
    logic [22:0]            frate_reg;
    logic [22:0]            srate_reg;
    logic [22:0]            lrate_reg;

    // detector state
    logic [ENERGY_BITS-1:0] fast_reg, slow_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [19:0]            refr_reg;

    // per-item work registers
    logic [ENERGY_BITS-1:0] energy_reg;
    logic [19:0]            dt_reg;
    logic                   dt_zero_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [16:0]            a0_reg, diffa_reg, alpha_reg;
    logic [15:0]            frac_reg;
    logic                   asat_reg;
    logic                   ge_reg;
    logic [QUO_W-1:0]       shaped_reg;
    logic [17:0]            factor_reg;
    logic                   fire_reg, ssat_reg, over_gt_reg;
    logic [17:0]            over_reg;
    logic                   onset_reg;
    logic [15:0]            strength_reg;
    logic                   out_onset_reg;
    logic [15:0]            out_strength_reg, out_level_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [22:0]        rate;
    logic [ENV_W-1:0]   prev, target, absdiff, step, env_new;
    logic [63:0]        pos;
    logic [IDX_W-1:0]   ix, ix_n;
    logic               in_range, last_seg;
    logic [16:0]        a0, a1;
    logic [16:0]        sens_cl;
    logic [DIV_W-1:0]   den_c, den_s;
    logic [DIV_W+1:0]   den_s3;
    logic [PROD_W:0]    fast_sh;
    logic               cond;
    logic [16:0]        over_d;
    div_cmd_t           dcmd;
    logic               div_busy;
    logic [QUO_W-1:0]   quo;

    aod_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dcmd),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign cfg.ready = 1'b1;

    always_comb
    begin
        case (cmd.sel)
            SEL_FAST:  rate = frate_reg;
            SEL_SLOW:  rate = srate_reg;
            SEL_LEVEL: rate = lrate_reg;
            default:   rate = frate_reg;
        endcase
        case (cmd.sel)
            SEL_FAST:
            begin
                prev   = ENV_W'(fast_reg);
                target = ENV_W'(energy_reg);
            end
            SEL_SLOW:
            begin
                prev   = ENV_W'(slow_reg);
                target = ENV_W'(energy_reg);
            end
            SEL_LEVEL:
            begin
                prev   = ENV_W'(level_reg);
                target = ENV_W'(shaped_reg);
            end
            default:
            begin
                prev   = ENV_W'(fast_reg);
                target = ENV_W'(energy_reg);
            end
        endcase
    end

    assign absdiff = (target >= prev) ? target - prev : prev - target;
    assign step    = ENV_W'((prod_reg + PROD_W'(32768)) >> 16);
    assign env_new = ge_reg ? prev + step : prev - step;

    // table position from dt * rate
    assign pos      = (64'(prod_reg) * 64'(ALPHA_TABLE_ENTRIES)) / 64'(ALPHA_X_SPAN);
    assign in_range = (pos[63:32] < 32'(ALPHA_TABLE_ENTRIES));
    assign ix       = pos[32 +: IDX_W];
    assign ix_n     = IDX_W'(ix + 1'b1);
    assign last_seg = ((32'(ix) + 32'd1) >= 32'(ALPHA_TABLE_ENTRIES));
    assign a0       = {1'b0, ALPHA_TAB[ix]};
    assign a1       = last_seg ? ONE_Q16 : {1'b0, ALPHA_TAB[ix_n]};

    assign sens_cl = (sens_reg > ONE_Q16) ? ONE_Q16 : sens_reg;
    assign den_c   = DIV_W'(fast_reg) + DIV_W'(KCOMP_L);
    assign den_s   = DIV_W'(slow_reg) + DIV_W'(EPS_L);
    assign den_s3  = (DIV_W+2)'(den_s) * (DIV_W+2)'(3);
    assign fast_sh = (PROD_W+1)'(fast_reg) << 16;
    assign cond    = (fast_reg > floor_reg) && (fast_sh > (PROD_W+1)'(prod_reg))
                     && (refr_reg == 20'd0);
    assign over_d  = 17'(over_reg - factor_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_AMUL:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = rate;
            end
            OP_AIMUL:
            begin
                mul_a = MUL_A_W'(diffa_reg);
                mul_b = MUL_B_W'(frac_reg);
            end
            OP_EMUL:
            begin
                mul_a = MUL_A_W'(absdiff);
                mul_b = MUL_B_W'(alpha_reg);
            end
            OP_FMUL:
            begin
                mul_a = MUL_A_W'(K165_Q16);
                mul_b = MUL_B_W'(sens_cl);
            end
            OP_TMUL:
            begin
                mul_a = MUL_A_W'(slow_reg);
                mul_b = MUL_B_W'(factor_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

    always_comb
    begin
        dcmd          = '0;
        dcmd.start    = 1'b0;
        case (cmd.op)
            OP_CDIV:
            begin
                dcmd.start    = 1'b1;
                dcmd.rem_init = DIV_W'(fast_reg);
                dcmd.low      = '0;
                dcmd.divisor  = den_c;
                dcmd.count    = 5'd24;
            end
            OP_ODIV:
            begin
                dcmd.start    = 1'b1;
                dcmd.rem_init = DIV_W'(fast_reg >> 2);
                dcmd.low      = {fast_reg[1:0], {(DIV_LO_W-2){1'b0}}};
                dcmd.divisor  = den_s;
                dcmd.count    = 5'd18;
            end
            OP_SDIV:
            begin
                dcmd.start    = 1'b1;
                dcmd.rem_init = DIV_W'(over_d >> 1);
                dcmd.low      = {over_d[0], {(DIV_LO_W-1){1'b0}}};
                dcmd.divisor  = DIV_W'(THREE_Q16 - factor_reg);
                dcmd.count    = 5'd17;
            end
            default:
            begin
                dcmd.start = 1'b0;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg  <= 17'd32768;
            floor_reg <= ENERGY_BITS'(168);
            refus_reg <= 20'd120000;
            frate_reg <= 23'd214748;
            srate_reg <= 23'd8590;
            lrate_reg <= 23'd53687;
            fast_reg  <= '0;
            slow_reg  <= '0;
            level_reg <= '0;
            refr_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_SENSITIVITY:   sens_reg  <= cfg.data[16:0];
                    CFG_ENERGY_FLOOR:  floor_reg <= cfg.data[ENERGY_BITS-1:0];
                    CFG_REFRACTORY_US: refus_reg <= cfg.data[19:0];
                    CFG_FAST_RATE:     frate_reg <= cfg.data[22:0];
                    CFG_SLOW_RATE:     srate_reg <= cfg.data[22:0];
                    CFG_LEVEL_RATE:    lrate_reg <= cfg.data[22:0];
                    default:           ;
                endcase
            end
            case (cmd.op)
                OP_REFR:
                    refr_reg <= (refr_reg > dt_reg) ? refr_reg - dt_reg : 20'd0;
                OP_EUPD:
                begin
                    case (cmd.sel)
                        SEL_FAST:  fast_reg  <= ENERGY_BITS'(env_new);
                        SEL_SLOW:  slow_reg  <= ENERGY_BITS'(env_new);
                        SEL_LEVEL: level_reg <= LEVEL_W'(env_new);
                        default:   ;
                    endcase
                end
                OP_TEST:
                    if (cond)
                        refr_reg <= refus_reg;
                default: ;
            endcase
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                energy_reg   <= frame.energy;
                dt_reg       <= frame.dt_us;
                dt_zero_reg  <= (frame.dt_us == 20'd0);
                onset_reg    <= 1'b0;
                strength_reg <= 16'd0;
                fire_reg     <= 1'b0;
            end
            OP_AMUL, OP_AIMUL, OP_FMUL, OP_TMUL:
                prod_reg <= mul_p;
            OP_AIDX:
            begin
                asat_reg  <= !in_range;
                a0_reg    <= a0;
                diffa_reg <= a1 - a0;
                frac_reg  <= pos[31:16];
            end
            OP_AINT:
                alpha_reg <= asat_reg ? ONE_Q16 : a0_reg + 17'(prod_reg >> 16);
            OP_EMUL:
            begin
                prod_reg <= mul_p;
                ge_reg   <= (target >= prev);
            end
            OP_SHAPE:
                shaped_reg <= quo;
            OP_FACT:
                factor_reg <= 18'(PROD_W'(THREE_Q16) - ((prod_reg + PROD_W'(32768)) >> 16));
            OP_TEST:
            begin
                fire_reg  <= cond;
                onset_reg <= cond;
                ssat_reg  <= (den_s == '0) || ((DIV_W+2)'(fast_reg) > den_s3);
            end
            OP_SAT:
                strength_reg <= 16'hFFFF;
            OP_OVER:
            begin
                over_reg    <= quo[17:0];
                over_gt_reg <= (quo[17:0] > factor_reg);
            end
            OP_STR:
                strength_reg <= (quo > QUO_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
            OP_WRITE:
            begin
                out_onset_reg    <= dt_zero_reg ? 1'b0 : onset_reg;
                out_strength_reg <= dt_zero_reg ? 16'd0 : strength_reg;
                out_level_reg    <= dt_zero_reg ? 16'd0 : level_reg[23:8];
            end
            default: ;
        endcase
    end

    assign result.onset     = out_onset_reg;
    assign result.strength  = out_strength_reg;
    assign result.level_out = out_level_reg;

    assign sts.dt_zero  = dt_zero_reg;
    assign sts.fire     = fire_reg;
    assign sts.str_sat  = ssat_reg;
    assign sts.over_gt  = over_gt_reg;
    assign sts.div_busy = div_busy;

endmodule

// ===== hw/rtl/aod_ctrl.sv =====
// Sequencer of the onset detector: walks the datapath through one item and
// owns the channel handshakes. Depends on aod_pkg, aod_if.
module aod_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    output aod_pkg::dp_cmd_t  cmd,
    input  aod_pkg::dp_sts_t  sts,
    aod_frame_if.sink         frame,
    aod_result_if.source      result
);
    import aod_pkg::*;

    ctrl_state_t state_reg, state_next;
    env_sel_t    sel_reg, sel_next;
    logic        out_valid_reg, out_valid_next;
    logic        can_load;

    assign can_load = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_FAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !result.ready;
        cmd.op         = OP_NONE;
        cmd.sel        = sel_reg;
        case (state_reg)
            ST_IDLE:
                if (frame.valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            ST_CHECK:
            begin
                sel_next   = SEL_FAST;
                state_next = sts.dt_zero ? ST_WRITE : ST_REFR;
            end
            ST_REFR:
            begin
                cmd.op     = OP_REFR;
                state_next = ST_AMUL;
            end
            ST_AMUL:
            begin
                cmd.op     = OP_AMUL;
                state_next = ST_AIDX;
            end
            ST_AIDX:
            begin
                cmd.op     = OP_AIDX;
                state_next = ST_AIMUL;
            end
            ST_AIMUL:
            begin
                cmd.op     = OP_AIMUL;
                state_next = ST_AINT;
            end
            ST_AINT:
            begin
                cmd.op     = OP_AINT;
                state_next = ST_EMUL;
            end
            ST_EMUL:
            begin
                cmd.op     = OP_EMUL;
                state_next = ST_EUPD;
            end
            ST_EUPD:
            begin
                cmd.op = OP_EUPD;
                case (sel_reg)
                    SEL_FAST:
                    begin
                        sel_next   = SEL_SLOW;
                        state_next = ST_AMUL;
                    end
                    SEL_SLOW:  state_next = ST_CDIV;
                    SEL_LEVEL: state_next = ST_FMUL;
                    default:   state_next = ST_FMUL;
                endcase
            end
            ST_CDIV:
            begin
                cmd.op     = OP_CDIV;
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
                if (!sts.div_busy)
                    state_next = ST_SHAPE;
            ST_SHAPE:
            begin
                cmd.op     = OP_SHAPE;
                sel_next   = SEL_LEVEL;
                state_next = ST_AMUL;
            end
            ST_FMUL:
            begin
                cmd.op     = OP_FMUL;
                state_next = ST_FACT;
            end
            ST_FACT:
            begin
                cmd.op     = OP_FACT;
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.op     = OP_TEST;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
                if (!sts.fire)
                    state_next = ST_WRITE;
                else if (sts.str_sat)
                    state_next = ST_SAT;
                else
                    state_next = ST_ODIV;
            ST_SAT:
            begin
                cmd.op     = OP_SAT;
                state_next = ST_WRITE;
            end
            ST_ODIV:
            begin
                cmd.op     = OP_ODIV;
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
                if (!sts.div_busy)
                    state_next = ST_OVER;
            ST_OVER:
            begin
                cmd.op     = OP_OVER;
                state_next = ST_OBRANCH;
            end
            ST_OBRANCH:
                state_next = sts.over_gt ? ST_SDIV : ST_WRITE;
            ST_SDIV:
            begin
                cmd.op     = OP_SDIV;
                state_next = ST_SWAIT;
            end
            ST_SWAIT:
                if (!sts.div_busy)
                    state_next = ST_STR;
            ST_STR:
            begin
                cmd.op     = OP_STR;
                state_next = ST_WRITE;
            end
            ST_WRITE:
                if (can_load)
                begin
                    cmd.op         = OP_WRITE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign frame.ready  = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;

endmodule
